FILE: src/tmd_pkg.sv
// Package with shared types, constants and codes of the track mark detector.
`default_nettype none
package tmd_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_SLOTS = 8;
   localparam int SAMPLE_W = 8;
   localparam int POSITION_W = 10;
   localparam int WINDOW_W = 10;
   localparam int MARK_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int POS_W = 16;

   localparam logic [SAMPLE_W-1:0] HIT_THRESHOLD_RESET = 8'd204;
   localparam logic [WINDOW_W-1:0] SIDE_WINDOW_RESET = 10'd64;
   localparam logic signed [POS_W-1:0] SPAN = POS_W'(SENSOR_COUNT - 1);

   typedef enum logic [MARK_W-1:0] {
      KIND_NONE  = 3'd0,
      KIND_LEFT  = 3'd1,
      KIND_RIGHT = 3'd2,
      KIND_BOTH  = 3'd3,
      KIND_CROSS = 3'd4
   } mark_kind_type;

   typedef enum logic {
      REG_HIT_THRESHOLD = 1'b0,
      REG_SIDE_WINDOW   = 1'b1
   } reg_index_type;

   typedef logic [SAMPLE_SLOTS-1:0][SAMPLE_W-1:0] sample_array_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] hit_threshold;
      logic [WINDOW_W-1:0] side_window;
   } cfg_type;

   typedef struct packed {
      logic [SENSOR_COUNT-1:0] hits;
      logic                    side_left;
      logic                    side_right;
   } eval_type;

   function automatic logic signed [POS_W-1:0] sensor_position(input int idx);
      sensor_position = POS_W'(idx * 512 - 256 * (SENSOR_COUNT - 1));
   endfunction

endpackage
`default_nettype wire

FILE: src/tmd_req_if.sv
// Input channel interface carrying the sensor samples and the line position.
`default_nettype none
interface tmd_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        sample_0;
   logic [7:0]        sample_1;
   logic [7:0]        sample_2;
   logic [7:0]        sample_3;
   logic [7:0]        sample_4;
   logic [7:0]        sample_5;
   logic [7:0]        sample_6;
   logic [7:0]        sample_7;
   logic signed [9:0] line_position;

   modport source (
      output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
         sample_7, line_position,
      input  ready
   );
   modport sink (
      input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
         sample_7, line_position,
      output ready
   );
endinterface
`default_nettype wire

FILE: src/tmd_rsp_if.sv
// Result channel interface carrying the reported mark kind.
`default_nettype none
interface tmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mark_kind;

   modport source (output valid, mark_kind, input ready);
   modport sink (input valid, mark_kind, output ready);
endinterface
`default_nettype wire

FILE: src/tmd_csr.sv
// APB-style configuration registers for threshold and side window.
`default_nettype none
module tmd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tmd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tmd_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [tmd_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                           pready,
   output      tmd_pkg::cfg_type               cfg
);
   import tmd_pkg::*;

   logic [SAMPLE_W-1:0] hit_threshold_ff;
   logic [SAMPLE_W-1:0] hit_threshold_in;
   logic [WINDOW_W-1:0] side_window_ff;
   logic [WINDOW_W-1:0] side_window_in;
   logic                wr_en;
   reg_index_type       reg_index;

   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite;
   assign reg_index = reg_index_type'(paddr[2]);

   always_comb begin
      hit_threshold_in = hit_threshold_ff;
      side_window_in = side_window_ff;
      if (wr_en) begin
         case (reg_index)
            REG_HIT_THRESHOLD: begin
               hit_threshold_in = pwdata[SAMPLE_W-1:0];
            end
            REG_SIDE_WINDOW: begin
               side_window_in = pwdata[WINDOW_W-1:0];
            end
            default: begin
               hit_threshold_in = hit_threshold_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_HIT_THRESHOLD: prdata = CSR_DATA_W'(hit_threshold_ff);
         REG_SIDE_WINDOW:   prdata = CSR_DATA_W'(side_window_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_threshold_ff <= HIT_THRESHOLD_RESET;
         side_window_ff <= SIDE_WINDOW_RESET;
      end else begin
         hit_threshold_ff <= hit_threshold_in;
         side_window_ff <= side_window_in;
      end
   end

   assign cfg.hit_threshold = hit_threshold_ff;
   assign cfg.side_window = side_window_ff;
endmodule
`default_nettype wire

FILE: src/tmd_hit_eval.sv
// Per-sensor hit detection and left/right side classification for one item.
`default_nettype none
module tmd_hit_eval (
   input  wire tmd_pkg::sample_array_type           samples,
   input  wire logic signed [tmd_pkg::POSITION_W-1:0] line_position,
   input  wire tmd_pkg::cfg_type                    cfg,
   output      tmd_pkg::eval_type                   eval
);
   import tmd_pkg::*;

   logic signed [POS_W-1:0] pos_ext;
   logic signed [POS_W-1:0] win_ext;
   logic signed [POS_W-1:0] left_bound;
   logic signed [POS_W-1:0] right_bound;
   logic [SENSOR_COUNT-1:0] hit_vec;
   logic [SENSOR_COUNT-1:0] left_vec;
   logic [SENSOR_COUNT-1:0] right_vec;

   assign pos_ext = POS_W'(line_position);
   assign win_ext = signed'(POS_W'(cfg.side_window));
   assign left_bound = POS_W'((pos_ext - win_ext) * SPAN);
   assign right_bound = POS_W'((pos_ext + win_ext) * SPAN);

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         hit_vec[i] = samples[i] > cfg.hit_threshold;
         left_vec[i] = hit_vec[i] && (sensor_position(i) < left_bound);
         right_vec[i] = hit_vec[i] && !(sensor_position(i) < left_bound)
            && (sensor_position(i) > right_bound);
      end
   end

   assign eval.hits = hit_vec;
   assign eval.side_left = |left_vec;
   assign eval.side_right = |right_vec;
endmodule
`default_nettype wire

FILE: src/tmd_core.sv
// Input register, mark state machine and result register of the detector.
`default_nettype none
module tmd_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire tmd_pkg::sample_array_type             req_samples,
   input  wire logic signed [tmd_pkg::POSITION_W-1:0] req_line_position,
   input  wire tmd_pkg::cfg_type                      cfg,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [tmd_pkg::MARK_W-1:0]            rsp_mark_kind
);
   import tmd_pkg::*;

   logic                           stage_valid_ff;
   logic                           stage_valid_in;
   sample_array_type               samples_ff;
   logic signed [POSITION_W-1:0]   line_position_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   mark_kind_type                  mark_kind_ff;
   mark_kind_type                  mark_kind_in;
   logic                           accumulating_ff;
   logic                           accumulating_in;
   logic [SENSOR_COUNT-1:0]        hit_mask_ff;
   logic [SENSOR_COUNT-1:0]        hit_mask_in;
   logic                           left_seen_ff;
   logic                           left_seen_in;
   logic                           right_seen_ff;
   logic                           right_seen_in;
   eval_type                       eval;
   logic                           advance;
   logic                           side_hit;
   logic [SENSOR_COUNT-1:0]        mask_upd;
   logic                           left_upd;
   logic                           right_upd;

   tmd_hit_eval u_hit_eval (
      .samples       (samples_ff),
      .line_position (line_position_ff),
      .cfg           (cfg),
      .eval          (eval)
   );

   assign advance = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign stage_valid_in = req_valid || (stage_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign side_hit = eval.side_left || eval.side_right;
   assign mask_upd = hit_mask_ff | eval.hits;
   assign left_upd = left_seen_ff || eval.side_left;
   assign right_upd = right_seen_ff || eval.side_right;

   always_comb begin
      accumulating_in = accumulating_ff;
      hit_mask_in = hit_mask_ff;
      left_seen_in = left_seen_ff;
      right_seen_in = right_seen_ff;
      mark_kind_in = mark_kind_ff;
      if (advance) begin
         mark_kind_in = KIND_NONE;
         hit_mask_in = mask_upd;
         left_seen_in = left_upd;
         right_seen_in = right_upd;
         if (!accumulating_ff) begin
            if (side_hit) begin
               accumulating_in = 1'b1;
            end else begin
               hit_mask_in = '0;
               left_seen_in = 1'b0;
               right_seen_in = 1'b0;
            end
         end else if (!side_hit) begin
            accumulating_in = 1'b0;
            if (&mask_upd) begin
               mark_kind_in = KIND_CROSS;
            end else if (left_upd && right_upd) begin
               mark_kind_in = KIND_BOTH;
            end else if (left_upd) begin
               mark_kind_in = KIND_LEFT;
            end else if (right_upd) begin
               mark_kind_in = KIND_RIGHT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         accumulating_ff <= 1'b0;
         hit_mask_ff <= '0;
         left_seen_ff <= 1'b0;
         right_seen_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff <= out_valid_in;
         accumulating_ff <= accumulating_in;
         hit_mask_ff <= hit_mask_in;
         left_seen_ff <= left_seen_in;
         right_seen_ff <= right_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         samples_ff <= req_samples;
         line_position_ff <= req_line_position;
      end
      mark_kind_ff <= mark_kind_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_mark_kind = mark_kind_ff;

   assert property (@(posedge clock) disable iff (reset)
      advance && accumulating_ff && !side_hit |=> !accumulating_ff)
      else $error("Accumulate mode was not left on an item without a side hit.");

   assert property (@(posedge clock) disable iff (reset)
      advance && !accumulating_ff && !side_hit
      |=> hit_mask_ff == '0 && !left_seen_ff && !right_seen_ff)
      else $error("Idle item without a side hit did not clear mask and flags.");

   assert property (@(posedge clock) disable iff (reset)
      advance && !(accumulating_ff && !side_hit) |=> mark_kind_ff == KIND_NONE)
      else $error("A mark was reported without leaving accumulate mode.");

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |=> stage_valid_ff)
      else $error("A pending item was dropped from the input register.");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("An evaluated item did not produce a result.");
endmodule
`default_nettype wire

FILE: src/track_mark_detector_unit.sv
// Top level of the track mark detector with channel and register ports.
//
//  Port group  Direction  Contents
//  req_chan    in         sample_0..sample_7, line_position
//  rsp_chan    out        mark_kind
//  APB port    in/out     hit_threshold at 0x0, side_window at 0x4
//
// One item is taken every cycle while the result is not stalled; its result is
// registered first in the input register and then in the result register.
// Reset clears the mode, mask, flags and valid bits and loads the register defaults.
// A stalled result holds the result register, and the input register holds one
// more item, so input transfers continue until both are full.
`default_nettype none
module track_mark_detector_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tmd_req_if.sink                             req_chan,
   tmd_rsp_if.source                           rsp_chan,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tmd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tmd_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [tmd_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                           pready
);
   import tmd_pkg::*;

   cfg_type          cfg;
   sample_array_type samples;

   assign samples = {req_chan.sample_7, req_chan.sample_6, req_chan.sample_5,
      req_chan.sample_4, req_chan.sample_3, req_chan.sample_2, req_chan.sample_1,
      req_chan.sample_0};

   tmd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmd_core u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_samples       (samples),
      .req_line_position (req_chan.line_position),
      .cfg               (cfg),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_mark_kind     (rsp_chan.mark_kind)
   );
endmodule
`default_nettype wire
